### sv/mlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared constants, codes, controller/datapath interface structs and the
// tanh lookup table builder for the tanh MLP forward-pass engine.
// ----------------------------------------------------------------------------
package mlp_pkg;

  localparam int WEIGHT_DEPTH = 65536;
  localparam int NODE_DEPTH   = 1024;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_LAYERS   = 7;

  localparam int WADDR_W = $clog2(WEIGHT_DEPTH);
  localparam int NADDR_W = $clog2(NODE_DEPTH);
  localparam int CFG_W   = 9;
  localparam int LC_W    = 3;
  localparam int CIDX_W  = 4;
  localparam int IDX_W   = 16;
  localparam int VAL_W   = 16;
  localparam int NSUM_W  = CFG_W + 3;
  localparam int PROD_W  = 2 * CFG_W;
  localparam int WSUM_W  = PROD_W + 3;
  localparam int MUL_W   = 2 * VAL_W;
  localparam int ACC_W   = MUL_W + 8;

  localparam int TANH_ENTRIES = 2048;
  localparam int TIDX_W       = $clog2(TANH_ENTRIES);
  localparam int TANH_W       = 14;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4261543595;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_LAYER_COUNT = 4'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH_FIRST = 4'd1;
  localparam logic [CIDX_W-1:0] REG_WIDTH_LAST  = 4'd7;

  typedef enum logic [1:0] {
    REQ_WRITE_WEIGHT = 2'd0,
    REQ_WRITE_INPUT  = 2'd1,
    REQ_FORWARD      = 2'd2,
    REQ_READ_OUTPUT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_BAD_SIZES = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  typedef struct packed {
    logic clr_step;
    logic lay_init;
    logic lay_step;
    logic lay_finish;
    logic capture;
    logic exec;
    logic respond_read;
    logic respond_zero;
    logic fw_init;
    logic mac_issue;
    logic tanh_index;
    logic tanh_lookup;
    logic tanh_write;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic dirty;
    logic lay_last;
    logic out_free;
    logic ex_fwd;
    logic ex_read;
    logic last_input;
    logic last_node;
    logic top_lyr;
  } ctl_sts_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_ENTRIES];

  // Entry k is round(8192 * tanh(k/256)), with e^(-k/128) stepped in Q0.32.
  function automatic tanh_rom_t build_tanh();
    tanh_rom_t   tab;
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] dvs;
    one = 64'd1 << 32;
    t   = one;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      num = (one - t) * 64'd8192;
      den = one + t;
      // restoring division: the rounded quotient never exceeds 8192
      rem = 64'd2 * num + den;
      dvs = 64'd2 * den;
      q   = '0;
      for (int b = TANH_W - 1; b >= 0; b--) begin
        if (rem >= (dvs << b)) begin
          rem  = rem - (dvs << b);
          q[b] = 1'b1;
        end
      end
      tab[k] = q[TANH_W-1:0];
      t      = (t * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

endpackage

### sv/mlp_tanh_forward_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_tanh_forward_pass
// Fixed-point tanh multilayer perceptron with weight/input load, forward
// pass and output read requests.
// ----------------------------------------------------------------------------
// Each request returns exactly one result. A forward pass runs one
// multiply-accumulate per weight through a single MAC pipeline fed by one
// read port on each memory; each computed node then goes through drain,
// tanh lookup and write-back. After reset the activation memory is swept
// to zero and the layout is computed; every configuration write triggers a
// new layout pass before the next request is taken. Results wait in an
// output register; a new request is taken once that register is free or
// being drained.
module mlp_tanh_forward_pass (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // index[15:0], value[31:16]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_value[15:0]
  output logic [1:0]  m_tuser    // status[1:0]
);

  mlp_pkg::ctl_cmd_t cmd;
  mlp_pkg::ctl_sts_t sts;
  logic signed [mlp_pkg::VAL_W-1:0] out_value;

  mlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_req     (s_tuser),
    .in_index   (s_tdata[15:0]),
    .in_value   (s_tdata[31:16]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_value  (out_value),
    .out_status (m_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign m_tdata = out_value;

endmodule

### sv/mlp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_ctrl
// Sequencer: memory clear, layout pass, request dispatch and forward pass.
// ----------------------------------------------------------------------------
module mlp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  mlp_pkg::ctl_sts_t   sts,
  output mlp_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_LAY_INIT, S_LAY_STEP, S_LAY_FIN, S_IDLE, S_EXEC, S_RESP,
    S_FW_INIT, S_MAC, S_D1, S_D2, S_TIDX, S_TROM, S_TWRITE, S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == S_IDLE) && !sts.dirty && sts.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd              = '0;
    cmd.clr_step     = (state == S_CLEAR);
    cmd.lay_init     = (state == S_LAY_INIT);
    cmd.lay_step     = (state == S_LAY_STEP);
    cmd.lay_finish   = (state == S_LAY_FIN);
    cmd.capture      = accept;
    cmd.exec         = (state == S_EXEC);
    cmd.respond_read = (state == S_RESP);
    cmd.respond_zero = (state == S_DONE);
    cmd.fw_init      = (state == S_FW_INIT);
    cmd.mac_issue    = (state == S_MAC);
    cmd.tanh_index   = (state == S_TIDX);
    cmd.tanh_lookup  = (state == S_TROM);
    cmd.tanh_write   = (state == S_TWRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR:    if (sts.clr_done) state <= S_LAY_INIT;
        S_LAY_INIT: state <= S_LAY_STEP;
        S_LAY_STEP: if (sts.lay_last) state <= S_LAY_FIN;
        S_LAY_FIN:  state <= S_IDLE;
        S_IDLE: begin
          if (sts.dirty) state <= S_LAY_INIT;
          else if (accept) state <= S_EXEC;
        end
        S_EXEC: begin
          if (sts.ex_fwd) state <= S_FW_INIT;
          else if (sts.ex_read) state <= S_RESP;
          else state <= S_IDLE;
        end
        S_RESP:     state <= S_IDLE;
        S_FW_INIT:  state <= S_MAC;
        S_MAC:      if (sts.last_input) state <= S_D1;
        S_D1:       state <= S_D2;
        S_D2:       state <= S_TIDX;
        S_TIDX:     state <= S_TROM;
        S_TROM:     state <= S_TWRITE;
        S_TWRITE: begin
          if (sts.last_node && sts.top_lyr) state <= S_DONE;
          else state <= S_MAC;
        end
        S_DONE:     state <= S_IDLE;
        default:    state <= S_CLEAR;
      endcase
    end
  end

endmodule

### sv/mlp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_datapath
// Config registers, layout, weight and activation memories, MAC pipeline,
// tanh lookup and the output register.
// ----------------------------------------------------------------------------
module mlp_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mlp_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [mlp_pkg::CFG_W-1:0]         cfg_data,
  input  logic [1:0]                        in_req,
  input  logic [mlp_pkg::IDX_W-1:0]         in_index,
  input  logic signed [mlp_pkg::VAL_W-1:0]  in_value,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic signed [mlp_pkg::VAL_W-1:0]  out_value,
  output logic [1:0]                        out_status,
  input  mlp_pkg::ctl_cmd_t                 cmd,
  output mlp_pkg::ctl_sts_t                 sts
);

  localparam mlp_pkg::tanh_rom_t TanhRom = mlp_pkg::build_tanh();

  // configuration
  logic [mlp_pkg::LC_W-1:0]  layer_count;
  logic [mlp_pkg::CFG_W-1:0] width [mlp_pkg::MAX_LAYERS];
  logic                      dirty;

  // layout
  logic [mlp_pkg::LC_W-1:0]   lstep;
  logic [mlp_pkg::NSUM_W-1:0] nsum;
  logic [mlp_pkg::WSUM_W-1:0] wsum;
  logic [mlp_pkg::NSUM_W-1:0] nbase [mlp_pkg::MAX_LAYERS];
  logic                       bad;

  // request
  logic [1:0]                       req_q;
  logic [mlp_pkg::IDX_W-1:0]        idx_q;
  logic signed [mlp_pkg::VAL_W-1:0] val_q;

  // memories
  logic signed [mlp_pkg::VAL_W-1:0] wmem [mlp_pkg::WEIGHT_DEPTH];
  logic signed [mlp_pkg::VAL_W-1:0] amem [mlp_pkg::NODE_DEPTH];
  logic signed [mlp_pkg::VAL_W-1:0] w_rd;
  logic signed [mlp_pkg::VAL_W-1:0] a_rd;
  logic [mlp_pkg::NADDR_W-1:0]      clr_addr;

  // forward pass
  logic [mlp_pkg::LC_W-1:0]    lyr;
  logic [mlp_pkg::CFG_W-1:0]   node;
  logic [mlp_pkg::CFG_W-1:0]   inp;
  logic [mlp_pkg::WADDR_W-1:0] wptr;
  logic [mlp_pkg::NADDR_W-1:0] abase;
  logic [mlp_pkg::NADDR_W-1:0] optr;
  logic                        rd_v;
  logic                        prod_v;
  logic signed [mlp_pkg::MUL_W-1:0] prod;
  logic signed [mlp_pkg::ACC_W-1:0] acc;
  logic [mlp_pkg::TIDX_W-1:0]  tidx;
  logic                        tneg_idx;
  logic [mlp_pkg::TANH_W-1:0]  tval;
  logic                        tneg;

  // combinational helpers
  logic [mlp_pkg::LC_W-1:0]    last_l;
  logic [mlp_pkg::CFG_W-1:0]   cur_w;
  logic [mlp_pkg::CFG_W-1:0]   prev_w;
  logic [mlp_pkg::PROD_W-1:0]  lay_prod;
  logic [mlp_pkg::ACC_W-1:0]   mag;
  logic [mlp_pkg::ACC_W:0]     rnd;
  logic [mlp_pkg::ACC_W-16:0]  rnd_idx;
  logic                        idx_ok;
  logic                        ex_fwd;
  logic                        ex_read;
  logic [mlp_pkg::NADDR_W-1:0] rd_addr;
  logic [mlp_pkg::NADDR_W-1:0] a_raddr;
  logic                        a_we;
  logic [mlp_pkg::NADDR_W-1:0] a_waddr;
  logic signed [mlp_pkg::VAL_W-1:0] a_wdata;
  logic signed [mlp_pkg::VAL_W-1:0] tanh_signed;
  logic                        resp_now;
  logic [1:0]                  resp_status;

  assign last_l   = layer_count - 3'd1;
  assign cur_w    = width[lstep];
  assign prev_w   = (lstep == '0) ? '0 : width[lstep - 3'd1];
  assign lay_prod = cur_w * prev_w;

  assign mag     = acc[mlp_pkg::ACC_W-1] ? mlp_pkg::ACC_W'(-acc) : mlp_pkg::ACC_W'(acc);
  assign rnd     = {1'b0, mag} + (mlp_pkg::ACC_W+1)'(32768);
  assign rnd_idx = rnd[mlp_pkg::ACC_W:16];

  assign tanh_signed = tneg ? -mlp_pkg::VAL_W'(tval) : mlp_pkg::VAL_W'(tval);

  assign rd_addr = mlp_pkg::NADDR_W'(nbase[last_l]) + idx_q[mlp_pkg::NADDR_W-1:0];

  // request decode
  always_comb begin
    idx_ok      = 1'b0;
    resp_status = mlp_pkg::ST_OK;
    ex_fwd      = 1'b0;
    ex_read     = 1'b0;
    case (req_q)
      mlp_pkg::REQ_WRITE_WEIGHT: idx_ok = ({5'd0, idx_q} < wsum);
      mlp_pkg::REQ_WRITE_INPUT:  idx_ok = (idx_q < {7'd0, width[0]});
      mlp_pkg::REQ_FORWARD:      idx_ok = 1'b1;
      mlp_pkg::REQ_READ_OUTPUT:  idx_ok = (idx_q < {7'd0, width[last_l]});
      default:                   idx_ok = 1'b0;
    endcase
    if (bad) begin
      resp_status = mlp_pkg::ST_BAD_SIZES;
    end else if (!idx_ok) begin
      resp_status = mlp_pkg::ST_RANGE;
    end else begin
      ex_fwd  = (req_q == mlp_pkg::REQ_FORWARD) && (layer_count != 3'd1);
      ex_read = (req_q == mlp_pkg::REQ_READ_OUTPUT);
    end
    resp_now = cmd.exec && !ex_fwd && !ex_read;
  end

  // activation memory port select
  always_comb begin
    a_we    = 1'b0;
    a_waddr = idx_q[mlp_pkg::NADDR_W-1:0];
    a_wdata = val_q;
    if (cmd.clr_step) begin
      a_we    = 1'b1;
      a_waddr = clr_addr;
      a_wdata = '0;
    end else if (cmd.tanh_write) begin
      a_we    = 1'b1;
      a_waddr = optr;
      a_wdata = tanh_signed;
    end else if (cmd.exec && !bad && idx_ok && req_q == mlp_pkg::REQ_WRITE_INPUT) begin
      a_we    = 1'b1;
    end
    a_raddr = cmd.mac_issue ? abase + mlp_pkg::NADDR_W'(inp) : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    a_rd <= amem[a_raddr];
    if (cmd.exec && !bad && idx_ok && req_q == mlp_pkg::REQ_WRITE_WEIGHT) begin
      wmem[idx_q] <= val_q;
    end
    w_rd <= wmem[wptr];
  end

  // config registers and dirty flag
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd7;
      width[0] <= 9'd32;  width[1] <= 9'd16;  width[2] <= 9'd32;
      width[3] <= 9'd32;  width[4] <= 9'd64;  width[5] <= 9'd128;
      width[6] <= 9'd256;
      dirty <= 1'b1;
    end else begin
      if (cfg_we && cfg_index == mlp_pkg::REG_LAYER_COUNT) begin
        layer_count <= cfg_data[mlp_pkg::LC_W-1:0];
      end else if (cfg_we && cfg_index >= mlp_pkg::REG_WIDTH_FIRST &&
                   cfg_index <= mlp_pkg::REG_WIDTH_LAST) begin
        width[mlp_pkg::LC_W'(cfg_index - mlp_pkg::REG_WIDTH_FIRST)] <= cfg_data;
      end
      if (cfg_we) dirty <= 1'b1;
      else if (cmd.lay_init) dirty <= 1'b0;
    end
  end

  // clear sweep, layout pass, control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      lstep    <= '0;
      bad      <= 1'b1;
      m_tvalid <= 1'b0;
      rd_v     <= 1'b0;
      prod_v   <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.lay_init) begin
        lstep <= '0;
        bad   <= (layer_count == '0);
      end else if (cmd.lay_step) begin
        lstep <= lstep + 1'b1;
        if (lstep < layer_count && (cur_w == '0 || cur_w > mlp_pkg::CFG_W'(mlp_pkg::MAX_WIDTH)))
          bad <= 1'b1;
      end else if (cmd.lay_finish) begin
        if (nsum > mlp_pkg::NSUM_W'(mlp_pkg::NODE_DEPTH) ||
            wsum > mlp_pkg::WSUM_W'(mlp_pkg::WEIGHT_DEPTH))
          bad <= 1'b1;
      end
      // output register: drop when taken, load on a response
      if (resp_now || cmd.respond_read || cmd.respond_zero) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      rd_v   <= cmd.mac_issue;
      prod_v <= rd_v;
    end
  end

  // layout sums and payload registers
  always_ff @(posedge clk) begin
    if (cmd.lay_init) begin
      nsum <= '0;
      wsum <= '0;
    end else if (cmd.lay_step && lstep < layer_count) begin
      nbase[lstep] <= nsum;
      nsum <= nsum + mlp_pkg::NSUM_W'(cur_w);
      wsum <= wsum + mlp_pkg::WSUM_W'(lay_prod);
    end
    if (cmd.capture) begin
      req_q <= in_req;
      idx_q <= in_index;
      val_q <= in_value;
    end
    if (resp_now) begin
      out_value  <= '0;
      out_status <= resp_status;
    end else if (cmd.respond_read) begin
      out_value  <= a_rd;
      out_status <= mlp_pkg::ST_OK;
    end else if (cmd.respond_zero) begin
      out_value  <= '0;
      out_status <= mlp_pkg::ST_OK;
    end
  end

  // forward pass counters, MAC pipeline and tanh lookup
  always_ff @(posedge clk) begin
    if (cmd.fw_init) begin
      lyr   <= 3'd1;
      node  <= '0;
      inp   <= '0;
      wptr  <= '0;
      abase <= mlp_pkg::NADDR_W'(nbase[0]);
      optr  <= mlp_pkg::NADDR_W'(nbase[1]);
    end else if (cmd.mac_issue) begin
      inp  <= inp + 1'b1;
      wptr <= wptr + 1'b1;
    end else if (cmd.tanh_write) begin
      inp  <= '0;
      optr <= optr + 1'b1;
      if (sts.last_node) begin
        node  <= '0;
        lyr   <= lyr + 1'b1;
        abase <= mlp_pkg::NADDR_W'(nbase[lyr]);
      end else begin
        node <= node + 1'b1;
      end
    end
    prod <= w_rd * a_rd;
    if (cmd.fw_init || cmd.tanh_write) acc <= '0;
    else if (prod_v) acc <= acc + mlp_pkg::ACC_W'(prod);
    if (cmd.tanh_index) begin
      tneg_idx <= acc[mlp_pkg::ACC_W-1];
      tidx     <= (rnd_idx > (mlp_pkg::ACC_W-15)'(mlp_pkg::TANH_ENTRIES - 1)) ?
                  mlp_pkg::TIDX_W'(mlp_pkg::TANH_ENTRIES - 1) : rnd_idx[mlp_pkg::TIDX_W-1:0];
    end
    if (cmd.tanh_lookup) begin
      tval <= TanhRom[tidx];
      tneg <= tneg_idx;
    end
  end

  assign sts.clr_done   = (clr_addr == '1);
  assign sts.dirty      = dirty;
  assign sts.lay_last   = (lstep == mlp_pkg::LC_W'(mlp_pkg::MAX_LAYERS - 1));
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.ex_fwd     = ex_fwd;
  assign sts.ex_read    = ex_read;
  assign sts.last_input = (inp == width[lyr - 3'd1] - 1'b1);
  assign sts.last_node  = (node == width[lyr] - 1'b1);
  assign sts.top_lyr    = (lyr == last_l);

`ifndef NO_ASSERTIONS
  a_resp_into_free: assert property (@(posedge clk) disable iff (rst)
    (resp_now || cmd.respond_read || cmd.respond_zero) |-> !m_tvalid)
    else $error("response loaded over a pending result");
  a_mac_good_cfg: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_issue |-> !bad && !dirty)
    else $error("MAC issued under a bad or stale layout");
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.tanh_write |=> acc == '0)
    else $error("accumulator not cleared after node write");
`endif

endmodule
